/* design/plc_pkg.sv */
`timescale 1ns / 1ps

package plc_pkg;

  // step counter of the correction program
  typedef logic [4:0] step_t;

  // datapath action selected by one control word
  typedef enum logic [3:0] {
    A_NOP,
    A_CLRK,
    A_LATCH1,
    A_INCK,
    A_ZERO0,
    A_SHIFT,
    A_MULA,
    A_MULB,
    A_DIVS,
    A_OUTQ,
    A_OUTMISS,
    A_OUTFULL
  } act_t;

  // jump condition selected by one control word
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_FULL,
    C_NZ,
    C_LAST,
    C_BELOW,
    C_KEND,
    C_ABOVE,
    C_DIVMORE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic full;
    logic nz;
    logic last;
    logic below;
    logic kend;
    logic above;
    logic divmore;
  } flags_t;

  // program addresses
  localparam step_t P_INIT  = 5'd0;
  localparam step_t P_SCANW = 5'd1;
  localparam step_t P_SCANT = 5'd2;
  localparam step_t P_SCANL = 5'd3;
  localparam step_t P_SCANI = 5'd4;
  localparam step_t P_BELOW = 5'd5;
  localparam step_t P_SEGE  = 5'd6;
  localparam step_t P_SEGI  = 5'd7;
  localparam step_t P_SEGW  = 5'd8;
  localparam step_t P_SEGT  = 5'd9;
  localparam step_t P_SEGJ  = 5'd10;
  localparam step_t P_MULA  = 5'd11;
  localparam step_t P_MULB  = 5'd12;
  localparam step_t P_DIV   = 5'd13;
  localparam step_t P_DONE  = 5'd14;
  localparam step_t P_MISS  = 5'd15;
  localparam step_t P_FULL  = 5'd16;

  // control store of the conversion program
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{act: A_NOP, cond: C_NEVER, target: P_INIT, last: 1'b1};
    unique case (s)
      P_INIT:  w = '{act: A_CLRK,    cond: C_FULL,    target: P_FULL,  last: 1'b0};
      P_SCANW: w = '{act: A_NOP,     cond: C_NEVER,   target: P_INIT,  last: 1'b0};
      P_SCANT: w = '{act: A_LATCH1,  cond: C_NZ,      target: P_BELOW, last: 1'b0};
      P_SCANL: w = '{act: A_NOP,     cond: C_LAST,    target: P_MISS,  last: 1'b0};
      P_SCANI: w = '{act: A_INCK,    cond: C_ALWAYS,  target: P_SCANW, last: 1'b0};
      P_BELOW: w = '{act: A_ZERO0,   cond: C_BELOW,   target: P_MULA,  last: 1'b0};
      P_SEGE:  w = '{act: A_SHIFT,   cond: C_KEND,    target: P_MISS,  last: 1'b0};
      P_SEGI:  w = '{act: A_INCK,    cond: C_NEVER,   target: P_INIT,  last: 1'b0};
      P_SEGW:  w = '{act: A_NOP,     cond: C_NEVER,   target: P_INIT,  last: 1'b0};
      P_SEGT:  w = '{act: A_LATCH1,  cond: C_ABOVE,   target: P_MULA,  last: 1'b0};
      P_SEGJ:  w = '{act: A_NOP,     cond: C_ALWAYS,  target: P_SEGE,  last: 1'b0};
      P_MULA:  w = '{act: A_MULA,    cond: C_NEVER,   target: P_INIT,  last: 1'b0};
      P_MULB:  w = '{act: A_MULB,    cond: C_NEVER,   target: P_INIT,  last: 1'b0};
      P_DIV:   w = '{act: A_DIVS,    cond: C_DIVMORE, target: P_DIV,   last: 1'b0};
      P_DONE:  w = '{act: A_OUTQ,    cond: C_NEVER,   target: P_INIT,  last: 1'b1};
      P_MISS:  w = '{act: A_OUTMISS, cond: C_NEVER,   target: P_INIT,  last: 1'b1};
      P_FULL:  w = '{act: A_OUTFULL, cond: C_NEVER,   target: P_INIT,  last: 1'b1};
      default: w = '{act: A_NOP,     cond: C_NEVER,   target: P_INIT,  last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

/* design/adc_piecewise_linear_correction.sv */
`timescale 1ns / 1ps

// Piecewise-linear ADC code correction. A load transfer (in_op = 0) writes one
// breakpoint in the accept cycle and keeps busy low, so loads can follow back to
// back. A convert transfer (in_op = 1) raises busy and runs a small microcoded
// program: full scale goes straight to the result; otherwise the scan steps over
// each leading zero breakpoint and each segment passed, then two multiply steps
// and a bit-serial restoring divide of the 16 + CODE_BITS bit numerator. A convert
// below the first live breakpoint skips the segment scan. Busy stays high for as
// long as the scan, reading one breakpoint entry per pass, and the divider run.
// The result is shown on the out_ ports for one cycle with out_valid; the
// receiver cannot stall it and must take it then. Reset clears the valid bits,
// so every table entry reads as zero.
module adc_piecewise_linear_correction #(
  parameter int NUM_POINTS = 34,
  parameter int CODE_BITS  = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_op,
  input  logic [5:0]           in_bp_index,
  input  logic [CODE_BITS-1:0] in_bp_measured,
  input  logic [15:0]          in_bp_ideal,
  input  logic [CODE_BITS-1:0] in_raw_code,
  output logic                 out_valid,
  output logic [15:0]          out_corrected,
  output logic                 out_out_of_range
);

  localparam int IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int NUM_W = 16 + CODE_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;
  localparam logic [CODE_BITS-1:0] FULL_CODE = {CODE_BITS{1'b1}};
  localparam logic [NUM_W-1:0] FULL_VALUE =
    NUM_W'(((64'd1 << CODE_BITS) - 64'd1) << FRAC_BITS);
  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(NUM_POINTS - 1);
  localparam logic [IDX_W-1:0] K_END  = IDX_W'(NUM_POINTS - 2);

  // breakpoint memory with per-entry valid bits
  logic [CODE_BITS-1:0] mem_meas  [NUM_POINTS];
  logic [15:0]          mem_ideal [NUM_POINTS];
  logic [NUM_POINTS-1:0] valid_r;

  logic [CODE_BITS-1:0] rd_meas_r;
  logic [15:0]          rd_ideal_r;
  logic                 rd_vld_r;
  logic [CODE_BITS-1:0] rd_meas;
  logic [15:0]          rd_ideal;

  // datapath registers
  logic [IDX_W-1:0]     k_r;
  logic [CODE_BITS-1:0] c_r;
  logic [CODE_BITS-1:0] m0_r;
  logic [CODE_BITS-1:0] m1_r;
  logic [15:0]          i0_r;
  logic [15:0]          i1_r;
  logic [NUM_W-1:0]     num_r;
  logic [CODE_BITS-1:0] den_r;
  logic [CODE_BITS-1:0] rem_r;
  logic [CNT_W-1:0]     cnt_r;

  logic                 out_valid_r;
  logic [15:0]          out_corrected_r;
  logic                 out_out_of_range_r;

  logic                 accept;
  logic                 load_wr;
  logic                 go;
  plc_pkg::act_t        act;
  plc_pkg::flags_t      flags;
  logic                 seq_active;

  logic [CODE_BITS-1:0] span_hi;
  logic [CODE_BITS-1:0] span_lo;
  logic [NUM_W-1:0]     prod_a;
  logic [NUM_W-1:0]     prod_b;
  logic [CODE_BITS:0]   rem_sh;
  logic                 q_bit;
  logic [NUM_W-1:0]     clamped;

  assign accept  = start && !busy;
  assign load_wr = accept && (in_op == OP_LOAD) &&
                   ({1'b0, in_bp_index} < 7'(NUM_POINTS));
  assign go      = accept && (in_op == OP_CONVERT);

  // breakpoint write on load transfer
  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem_meas[in_bp_index[IDX_W-1:0]]  <= in_bp_measured;
      mem_ideal[in_bp_index[IDX_W-1:0]] <= in_bp_ideal;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (load_wr) begin
      valid_r[in_bp_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  // registered read at the scan index
  always_ff @(posedge clk) begin
    rd_meas_r  <= mem_meas[k_r];
    rd_ideal_r <= mem_ideal[k_r];
    rd_vld_r   <= valid_r[k_r];
  end

  assign rd_meas  = rd_vld_r ? rd_meas_r : '0;
  assign rd_ideal = rd_vld_r ? rd_ideal_r : '0;

  // status flags for the sequencer
  assign flags.full    = (c_r == FULL_CODE);
  assign flags.nz      = (rd_meas != '0);
  assign flags.last    = (k_r == K_LAST);
  assign flags.below   = (c_r < m1_r);
  assign flags.kend    = (k_r >= K_END);
  assign flags.above   = (rd_meas > c_r);
  assign flags.divmore = (cnt_r != CNT_W'(1));

  plc_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .flags  (flags),
    .act    (act),
    .active (seq_active)
  );

  // segment weights and products
  assign span_hi = m1_r - c_r;
  assign span_lo = c_r - m0_r;
  assign prod_a  = NUM_W'(i0_r) * NUM_W'(span_hi);
  assign prod_b  = NUM_W'(i1_r) * NUM_W'(span_lo);

  // one restoring divide step
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  assign clamped = (num_r > FULL_VALUE) ? FULL_VALUE : num_r;

  // datapath driven by the control word
  always_ff @(posedge clk) begin
    if (go) begin
      c_r <= in_raw_code;
    end
    unique case (act)
      plc_pkg::A_NOP: begin
      end
      plc_pkg::A_CLRK: begin
        k_r <= '0;
      end
      plc_pkg::A_LATCH1: begin
        m1_r <= rd_meas;
        i1_r <= rd_ideal;
      end
      plc_pkg::A_INCK: begin
        k_r <= k_r + IDX_W'(1);
      end
      plc_pkg::A_ZERO0: begin
        m0_r <= '0;
        i0_r <= '0;
      end
      plc_pkg::A_SHIFT: begin
        m0_r <= m1_r;
        i0_r <= i1_r;
      end
      plc_pkg::A_MULA: begin
        num_r <= prod_a;
        den_r <= m1_r - m0_r;
      end
      plc_pkg::A_MULB: begin
        num_r <= num_r + prod_b;
        rem_r <= '0;
        cnt_r <= CNT_W'(NUM_W);
      end
      plc_pkg::A_DIVS: begin
        rem_r <= q_bit ? CODE_BITS'(rem_sh - {1'b0, den_r}) : rem_sh[CODE_BITS-1:0];
        num_r <= {num_r[NUM_W-2:0], q_bit};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      plc_pkg::A_OUTQ, plc_pkg::A_OUTMISS, plc_pkg::A_OUTFULL: begin
      end
      default: begin
      end
    endcase
  end

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (act == plc_pkg::A_OUTQ) || (act == plc_pkg::A_OUTMISS) ||
                     (act == plc_pkg::A_OUTFULL);
    end
    if (act == plc_pkg::A_OUTQ) begin
      out_corrected_r    <= clamped[15:0];
      out_out_of_range_r <= 1'b0;
    end else if (act == plc_pkg::A_OUTMISS) begin
      out_corrected_r    <= '0;
      out_out_of_range_r <= 1'b1;
    end else if (act == plc_pkg::A_OUTFULL) begin
      out_corrected_r    <= FULL_VALUE[15:0];
      out_out_of_range_r <= 1'b0;
    end
  end

  assign busy             = seq_active;
  assign out_valid        = out_valid_r;
  assign out_corrected    = out_corrected_r;
  assign out_out_of_range = out_out_of_range_r;

endmodule

/* design/plc_useq.sv */
`timescale 1ns / 1ps

module plc_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  plc_pkg::flags_t flags,
  output plc_pkg::act_t   act,
  output logic            active
);

  logic            active_r;
  plc_pkg::step_t  pc_r;
  plc_pkg::ctrl_t  ctrl;
  logic            hit;

  // fetch the control word of the current step
  assign ctrl = plc_pkg::ucode(pc_r);

  // jump condition select
  always_comb begin
    unique case (ctrl.cond)
      plc_pkg::C_NEVER:   hit = 1'b0;
      plc_pkg::C_ALWAYS:  hit = 1'b1;
      plc_pkg::C_FULL:    hit = flags.full;
      plc_pkg::C_NZ:      hit = flags.nz;
      plc_pkg::C_LAST:    hit = flags.last;
      plc_pkg::C_BELOW:   hit = flags.below;
      plc_pkg::C_KEND:    hit = flags.kend;
      plc_pkg::C_ABOVE:   hit = flags.above;
      plc_pkg::C_DIVMORE: hit = flags.divmore;
      default:            hit = 1'b0;
    endcase
  end

  // step counter with conditional jump
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pc_r     <= plc_pkg::P_INIT;
    end else if (go) begin
      active_r <= 1'b1;
      pc_r     <= plc_pkg::P_INIT;
    end else if (active_r) begin
      if (ctrl.last) begin
        active_r <= 1'b0;
      end else if (hit) begin
        pc_r <= ctrl.target;
      end else begin
        pc_r <= pc_r + 5'd1;
      end
    end
  end

  assign act    = active_r ? ctrl.act : plc_pkg::A_NOP;
  assign active = active_r;

endmodule
